// File: rtl/tpsc_pkg.sv
// Shared types, register indexes and reset values for the time-of-flight pair slip corrector.
package tpsc_pkg;

  // Default ring depth for the sample slot index.
  localparam int unsigned RingDepthDef = 30;

  // Widths of the data fields.
  localparam int unsigned RawW  = 32;
  localparam int unsigned TimeW = 34;
  localparam int unsigned DiffW = 22;
  localparam int unsigned SlipW = 21;
  localparam int unsigned SlotW = 5;
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned OutDataW = 144;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgAcceptMin = 8'd0;
  localparam logic [CfgIdxW-1:0] CfgAcceptMax = 8'd1;
  localparam logic [CfgIdxW-1:0] CfgMaxUp     = 8'd2;
  localparam logic [CfgIdxW-1:0] CfgSlipStep  = 8'd3;

  // Reset values, in 2^-18 microsecond units.
  localparam logic signed [DiffW-1:0] AcceptMinRst = -22'sd13107;
  localparam logic signed [DiffW-1:0] AcceptMaxRst = 22'sd104858;
  localparam logic [RawW-1:0]         MaxUpRst     = 32'd65536000;
  localparam logic [SlipW-1:0]        SlipStepRst  = 21'd131072;

  // Configuration register set.
  typedef struct packed {
    logic signed [DiffW-1:0] accept_min;
    logic signed [DiffW-1:0] accept_max;
    logic [RawW-1:0]         max_up;
    logic [SlipW-1:0]        slip_step;
  } cfg_t;

  // Result of the pair calculation.
  typedef struct packed {
    logic signed [TimeW-1:0] down_time;
    logic signed [TimeW-1:0] time_diff;
    logic                    accepted;
  } calc_t;

endpackage

// File: rtl/tof_pair_slip_correct.sv
// Top level of the time-of-flight pair slip corrector: input stage, pair state, result register.
// A downstream beat is loaded into the input register when it is accepted and into the result
// register as it leaves; it waits in the input register while the result register is full.
// Throughput: one input beat per cycle unless a downstream beat waits for a free result slot.
// Reset clears the pipeline valid bits, the pair phase, held upstream time, sample count
// and ring slot, and loads the configuration registers with their default values.
module tof_pair_slip_correct #(
  parameter int unsigned RING_DEPTH = tpsc_pkg::RingDepthDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [tpsc_pkg::RawW-1:0]       s_axis_tdata,  // [31:0] raw_result
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [31:0] upstream_time, [65:32] downstream_time, [99:66] time_difference,
  // [100] accepted, [105:101] slot_index, [137:106] samples_taken, [143:138] zero
  output logic [tpsc_pkg::OutDataW-1:0]   m_axis_tdata,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [tpsc_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [tpsc_pkg::CfgDataW-1:0]   cfg_data_i
);
  import tpsc_pkg::*;

  localparam int unsigned SlotIdxW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

  cfg_t  cfg;
  calc_t calc;

  logic                     in_valid_q;
  logic [RawW-1:0]          in_word_q;
  logic                     expect_down_q, expect_down_d;
  logic [RawW-1:0]          held_up_q, held_up_d;
  logic [RawW-1:0]          count_q, count_d;
  logic [SlotIdxW-1:0]      slot_q, slot_d;
  logic                     out_valid_q, out_valid_d;
  logic [RawW-1:0]          out_up_q;
  calc_t                    out_calc_q;
  logic [SlotW-1:0]         out_slot_q;
  logic [RawW-1:0]          out_count_q;
  logic                     out_free, in_adv, take_result;

  tpsc_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  tpsc_pair_calc u_calc (
    .cfg_i (cfg),
    .up_i  (held_up_q),
    .down_i(in_word_q),
    .calc_o(calc)
  );

  // Handshake: an upstream beat always moves on; a downstream beat needs a free result slot.
  assign out_free      = !out_valid_q || m_axis_tready;
  assign in_adv        = in_valid_q && (!expect_down_q || out_free);
  assign take_result   = in_adv && expect_down_q;
  assign s_axis_tready = !in_valid_q || in_adv;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_word_q <= s_axis_tdata;
    end
  end

  // Pair state update as a beat leaves the input register.
  always_comb begin
    expect_down_d = expect_down_q;
    held_up_d     = held_up_q;
    count_d       = count_q;
    slot_d        = slot_q;
    if (in_adv) begin
      expect_down_d = !expect_down_q;
      if (!expect_down_q) begin
        held_up_d = in_word_q;
      end else if (calc.accepted) begin
        count_d = count_q + 1'b1;
        slot_d  = (slot_q == SlotIdxW'(RING_DEPTH - 1)) ? '0 : slot_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expect_down_q <= 1'b0;
      held_up_q     <= '0;
      count_q       <= '0;
      slot_q        <= '0;
    end else begin
      expect_down_q <= expect_down_d;
      held_up_q     <= held_up_d;
      count_q       <= count_d;
      slot_q        <= slot_d;
    end
  end

  // Result register.
  always_comb begin
    out_valid_d = out_valid_q;
    if (take_result) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_result) begin
      out_up_q    <= held_up_q;
      out_calc_q  <= calc;
      out_slot_q  <= SlotW'(slot_q);
      out_count_q <= count_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'b0, out_count_q, out_slot_q, out_calc_q.accepted,
                          out_calc_q.time_diff, out_calc_q.down_time, out_up_q};

  // The ring slot never leaves its range.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot_q < SlotIdxW'(RING_DEPTH - 1) || slot_q == SlotIdxW'(RING_DEPTH - 1))
    else $error("ring slot out of range");

  // While a result waits, upstream beats cannot move the sample count away from it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_count_q == count_q)
    else $error("sample count moved under a pending result");

  // A downstream beat leaving the input register always loads a result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_result |=> out_valid_q)
    else $error("downstream beat lost");

  // An upstream beat never changes the sample count or the slot.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_adv && !expect_down_q) |=> $stable(count_q) && $stable(slot_q))
    else $error("upstream beat changed the count");

endmodule

// File: rtl/tpsc_cfg_regs.sv
// Configuration register file of the pair slip corrector.
module tpsc_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [tpsc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [tpsc_pkg::CfgDataW-1:0] cfg_data_i,
  output tpsc_pkg::cfg_t                cfg_o
);
  import tpsc_pkg::*;

  cfg_t cfg_q, cfg_d;

  // Writes are always taken; an unknown index leaves the registers alone.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgAcceptMin: cfg_d.accept_min = cfg_data_i[DiffW-1:0];
        CfgAcceptMax: cfg_d.accept_max = cfg_data_i[DiffW-1:0];
        CfgMaxUp:     cfg_d.max_up     = cfg_data_i[RawW-1:0];
        CfgSlipStep:  cfg_d.slip_step  = cfg_data_i[SlipW-1:0];
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.accept_min <= AcceptMinRst;
      cfg_q.accept_max <= AcceptMaxRst;
      cfg_q.max_up     <= MaxUpRst;
      cfg_q.slip_step  <= SlipStepRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: rtl/tpsc_pair_calc.sv
// Difference, half-period slip correction and acceptance test for one pair.
module tpsc_pair_calc (
  input  tpsc_pkg::cfg_t                 cfg_i,
  input  logic [tpsc_pkg::RawW-1:0]      up_i,
  input  logic [tpsc_pkg::RawW-1:0]      down_i,
  output tpsc_pkg::calc_t                calc_o
);
  import tpsc_pkg::*;

  logic signed [TimeW-1:0] up_s, down_s, diff0, slip_s, amin_s, amax_s;
  logic signed [TimeW-1:0] hi_lim, lo_lim, delta;
  logic                    above_slip, below_min, in_high, in_low, fix, add_slip, sub_slip;

  // Extend the operands to the common signed width.
  assign up_s   = signed'({2'b00, up_i});
  assign down_s = signed'({2'b00, down_i});
  assign slip_s = signed'({{(TimeW-SlipW){1'b0}}, cfg_i.slip_step});
  assign amin_s = {{(TimeW-DiffW){cfg_i.accept_min[DiffW-1]}}, cfg_i.accept_min};
  assign amax_s = {{(TimeW-DiffW){cfg_i.accept_max[DiffW-1]}}, cfg_i.accept_max};

  assign diff0  = up_s - down_s;
  assign hi_lim = slip_s + amax_s;
  assign lo_lim = amin_s - slip_s;

  // Slip windows on the uncorrected difference.
  assign above_slip = diff0 > slip_s;
  assign below_min  = diff0 < amin_s;
  assign in_high    = above_slip && (diff0 < hi_lim);
  assign in_low     = (diff0 > lo_lim) && below_min;
  assign fix        = in_high || in_low;
  assign add_slip   = fix && above_slip;
  assign sub_slip   = fix && below_min;

  // When both corrections apply they cancel.
  always_comb begin
    if (add_slip && !sub_slip) begin
      delta = slip_s;
    end else if (sub_slip && !add_slip) begin
      delta = -slip_s;
    end else begin
      delta = '0;
    end
  end

  assign calc_o.down_time = down_s + delta;
  assign calc_o.time_diff = diff0 - delta;
  assign calc_o.accepted  = (calc_o.time_diff > amin_s) && (calc_o.time_diff < amax_s) &&
                            (up_i < cfg_i.max_up);

endmodule
